// ===== src/xmc_pkg.sv =====
// shared types, constants and the crc step for the xmodem-crc receiver
// no dependencies; the modules and the testbench import this package
package xmc_pkg;

  localparam int BufferBytes = 1024;
  localparam int AddrW = $clog2(BufferBytes);
  localparam bit LongBlocksOk = (BufferBytes >= 1024);

  // result queue, depth must be a power of two
  localparam int QueueDepth = 8;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = QPtrW + 1;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] RegAllowLong  = 2'd0;
  localparam logic [1:0] RegStartRetry = 2'd1;
  localparam logic [1:0] RegTimeout    = 2'd2;
  localparam logic [1:0] RegErrLimit   = 2'd3;

  localparam logic        AllowLongRst  = 1'b1;
  localparam logic [15:0] StartRetryRst = 16'd500;
  localparam logic [15:0] TimeoutRst    = 16'd1000;
  localparam logic [7:0]  ErrLimitRst   = 8'd10;

  // link control characters
  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChC   = 8'h43;

  localparam logic [10:0] ShortLen = 11'd128;
  localparam logic [10:0] LongLen  = 11'd1024;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  typedef struct packed {
    logic [7:0]  send_byte;
    logic        packet_complete;
    logic        packet_delivered;
    logic [31:0] block_number;
    logic [10:0] packet_length;
    logic [7:0]  read_data;
    logic [3:0]  protocol_state;
    logic        last;
  } res_t;

  // results of one accepted word, registered on acceptance
  typedef struct packed {
    logic valid;
    logic two;
    logic rd;
    res_t r0;
    res_t r1;
  } stage_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ((x << 1) ^ CrcPoly) : (x << 1);
    end
    return x;
  endfunction

endpackage

// ===== src/xmc_in_if.sv =====
// input channel of the xmodem-crc receiver: command words with handshake
// no dependencies
interface xmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_data;
  logic [9:0] read_index;

  modport source (output valid, command, rx_data, read_index, input ready);
  modport sink (input valid, command, rx_data, read_index, output ready);
endinterface

// ===== src/xmc_out_if.sv =====
// result channel of the xmodem-crc receiver: one result word per handshake
// no dependencies
interface xmc_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_byte;
  logic        packet_complete;
  logic        packet_delivered;
  logic [31:0] block_number;
  logic [10:0] packet_length;
  logic [7:0]  read_data;
  logic [3:0]  protocol_state;
  logic        last;

  modport source (output valid, send_valid, send_byte, packet_complete, packet_delivered,
                  block_number, packet_length, read_data, protocol_state, last,
                  input ready);
  modport sink (input valid, send_valid, send_byte, packet_complete, packet_delivered,
                block_number, packet_length, read_data, protocol_state, last,
                output ready);
endinterface

// ===== src/xmodem_crc_receiver.sv =====
// xmodem-crc receiver top: control, payload ram and result queue
// depends on xmc_pkg, xmc_in_if, xmc_out_if, xmc_ctrl, xmc_payload_ram, xmc_out_queue
//
//   port       dir  handshake        carries
//   req        in   valid/ready      command, rx_data, read_index
//   rsp        out  valid/ready      one result word, last marks the final one
//   cfg_*      in   cfg_we only      register index and data, no read-back
//
// one command word per cycle while req.ready is high; its results enter the queue in the cycle
// after, with the payload ram read data, and leave one per cycle while rsp.ready is high.
// a tick may give two results, every other command one.
// req.ready is low while the 8-entry queue, counting staged results, has fewer than two free.
// synchronous reset, no clearing pass: unwritten payload bytes read undefined.
module xmodem_crc_receiver import xmc_pkg::*; (
  input logic        clk,
  input logic        rst,
  xmc_in_if.sink     req,
  xmc_out_if.source  rsp,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  logic             acc;
  ram_wr_t          wr;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       ram_q;
  stage_t           stage;
  res_t             r0_merged;
  logic [1:0]       push_n;
  res_t             head;
  logic             not_empty;
  logic [QCntW-1:0] q_cnt;
  logic             pop;

  assign acc = req.valid && req.ready;

  xmc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .command    (req.command),
    .rx_data    (req.rx_data),
    .read_index (req.read_index),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr         (wr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .stage      (stage)
  );

  xmc_payload_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .q       (ram_q)
  );

  always_comb begin
    r0_merged = stage.r0;
    if (stage.rd) begin
      r0_merged.read_data = ram_q;
    end
  end

  assign push_n = stage.valid ? (stage.two ? 2'd2 : 2'd1) : 2'd0;

  // room for the word in the stage plus two more from a new word
  assign req.ready = ((QCntW + 1)'(q_cnt) + (QCntW + 1)'(push_n) + (QCntW + 1)'(2))
                     <= (QCntW + 1)'(QueueDepth);

  xmc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .d0        (r0_merged),
    .d1        (stage.r1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .cnt       (q_cnt)
  );

  assign pop = rsp.valid && rsp.ready;
  assign rsp.valid = not_empty;
  assign rsp.send_valid = (head.send_byte != 8'h00);
  assign rsp.send_byte = head.send_byte;
  assign rsp.packet_complete = head.packet_complete;
  assign rsp.packet_delivered = head.packet_delivered;
  assign rsp.block_number = head.block_number;
  assign rsp.packet_length = head.packet_length;
  assign rsp.read_data = head.read_data;
  assign rsp.protocol_state = head.protocol_state;
  assign rsp.last = head.last;

endmodule

// ===== src/xmc_payload_ram.sv =====
// block payload memory: one write port, one read port with registered data
// depends on xmc_pkg
module xmc_payload_ram import xmc_pkg::*; (
  input  logic             clk,
  input  ram_wr_t          wr,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       q
);

  logic [7:0] mem [BufferBytes];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

endmodule

// ===== src/xmc_ctrl.sv =====
// framing and timer control: protocol state, running crc, config registers
// depends on xmc_pkg; drives the payload ram write port and the result stage
module xmc_ctrl import xmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic [1:0]       command,
  input  logic [7:0]       rx_data,
  input  logic [9:0]       read_index,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output ram_wr_t          wr,
  output logic             rd_en,
  output logic [AddrW-1:0] rd_addr,
  output stage_t           stage
);

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_HEADER  = 4'd1,
    PH_NUMBER  = 4'd2,
    PH_COMPL   = 4'd3,
    PH_DATA    = 4'd4,
    PH_CRCHI   = 4'd5,
    PH_CRCLO   = 4'd6,
    PH_READY   = 4'd7,
    PH_SUCCESS = 4'd8,
    PH_FAILURE = 4'd9
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] expected_block, expected_block_next;
  logic [10:0] block_length, block_length_next;
  logic [10:0] fill_position, fill_position_next;
  logic        is_repeat, is_repeat_next;
  logic [15:0] received_check, received_check_next;
  logic [15:0] running_check, running_check_next;
  logic [7:0]  fault_count, fault_count_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic        allow_long;
  logic [15:0] start_retry;
  logic [15:0] pkt_timeout;
  logic [7:0]  err_limit;
  stage_t      stage_next;

  logic [7:0]  nxt_b, cur_b, want_b;
  logic [15:0] el_inc, el_a;
  logic        ev_c, ev_to, ev_can, ev_ack;
  logic [7:0]  fault_a;
  phase_t      ph_a;
  logic [10:0] fill_inc;
  logic        in_range;
  res_t        r_empty;

  assign nxt_b = expected_block[7:0] + 8'd1;
  assign cur_b = expected_block[7:0];
  assign want_b = ~(is_repeat ? cur_b : nxt_b);
  assign fill_inc = fill_position + 11'd1;
  assign in_range = ({1'b0, read_index} < 11'(BufferBytes));

  // tick event chain, in the order the events are checked
  assign el_inc = (elapsed_ms != 16'hFFFF) ? elapsed_ms + 16'd1 : elapsed_ms;
  assign ev_c = (phase == PH_START) && (el_inc > start_retry);
  assign el_a = ev_c ? 16'd0 : el_inc;
  assign ev_to = (el_a > pkt_timeout);
  assign fault_a = (ev_to && fault_count != 8'hFF) ? fault_count + 8'd1 : fault_count;
  assign ph_a = ev_to ? PH_HEADER : phase;
  assign ev_can = (fault_a >= err_limit);
  assign ev_ack = !ev_can && (ph_a == PH_READY);

  assign wr.we = acc && (command == CMD_BYTE) && (phase == PH_DATA)
                 && (fill_position < 11'(BufferBytes));
  assign wr.addr = fill_position[AddrW-1:0];
  assign wr.data = rx_data;
  assign rd_en = acc && (command == CMD_READ) && in_range;
  assign rd_addr = read_index[AddrW-1:0];

  always_comb begin
    phase_next = phase;
    expected_block_next = expected_block;
    block_length_next = block_length;
    fill_position_next = fill_position;
    is_repeat_next = is_repeat;
    received_check_next = received_check;
    running_check_next = running_check;
    fault_count_next = fault_count;
    elapsed_ms_next = elapsed_ms;

    r_empty = '0;
    r_empty.protocol_state = phase;
    stage_next = '0;
    stage_next.valid = acc;
    stage_next.r0 = r_empty;
    stage_next.r0.last = 1'b1;

    unique case (cmd_t'(command))
      CMD_BYTE: begin
        unique case (phase)
          PH_START, PH_HEADER: begin
            priority if (rx_data == ChSoh) begin
              phase_next = PH_NUMBER;
              block_length_next = ShortLen;
            end else if (rx_data == ChStx && allow_long && LongBlocksOk) begin
              phase_next = PH_NUMBER;
              block_length_next = LongLen;
            end else if (rx_data == ChEot) begin
              phase_next = PH_SUCCESS;
              stage_next.r0.send_byte = ChAck;
            end
          end
          PH_NUMBER: begin
            priority if (rx_data == nxt_b) begin
              phase_next = PH_COMPL;
              is_repeat_next = 1'b0;
            end else if (rx_data == cur_b) begin
              phase_next = PH_COMPL;
              is_repeat_next = 1'b1;
            end else if (rx_data == ChSoh || rx_data == ChStx) begin
              phase_next = PH_NUMBER;
            end else begin
              phase_next = PH_HEADER;
            end
          end
          PH_COMPL: begin
            priority if (rx_data == want_b) begin
              fill_position_next = '0;
              running_check_next = '0;
              phase_next = PH_DATA;
            end else if (rx_data == ChSoh || rx_data == ChStx) begin
              phase_next = PH_NUMBER;
            end else begin
              phase_next = PH_HEADER;
            end
          end
          PH_DATA: begin
            running_check_next = crc16_byte(running_check, rx_data);
            fill_position_next = fill_inc;
            if (fill_inc >= block_length) begin
              phase_next = PH_CRCHI;
            end
          end
          PH_CRCHI: begin
            received_check_next = {rx_data, 8'h00};
            phase_next = PH_CRCLO;
          end
          PH_CRCLO: begin
            received_check_next = {received_check[15:8], rx_data};
            if ({received_check[15:8], rx_data} != running_check) begin
              fault_count_next = (fault_count != 8'hFF) ? fault_count + 8'd1 : fault_count;
              phase_next = PH_HEADER;
              stage_next.r0.send_byte = ChNak;
            end else begin
              phase_next = is_repeat ? PH_HEADER : PH_READY;
            end
          end
          default: begin
            // ready and done phases ignore received bytes
          end
        endcase
        stage_next.r0.protocol_state = phase_next;
        stage_next.r0.packet_complete = (phase_next == PH_READY);
      end

      CMD_TICK: begin
        if (phase != PH_SUCCESS && phase != PH_FAILURE) begin
          fault_count_next = fault_a;
          phase_next = ev_can ? PH_FAILURE : (ev_ack ? PH_HEADER : ph_a);
          elapsed_ms_next = (ev_c || ev_to || ev_can || ev_ack) ? 16'd0 : el_inc;
          if (ev_ack) begin
            expected_block_next = expected_block + 32'd1;
          end
          // only 'C' or NAK can be followed by CAN on the same tick
          priority if (ev_c) begin
            stage_next.r0.send_byte = ChC;
            stage_next.r0.protocol_state = PH_START;
          end else if (ev_to) begin
            stage_next.r0.send_byte = ChNak;
            stage_next.r0.protocol_state = PH_HEADER;
          end else if (ev_can) begin
            stage_next.r0.send_byte = ChCan;
            stage_next.r0.protocol_state = PH_FAILURE;
          end else if (ev_ack) begin
            stage_next.r0.send_byte = ChAck;
            stage_next.r0.packet_delivered = 1'b1;
            stage_next.r0.block_number = expected_block;
            stage_next.r0.packet_length = block_length;
            stage_next.r0.protocol_state = PH_HEADER;
          end else begin
            stage_next.r0.protocol_state = ph_a;
          end
          if (ev_can && (ev_c || ev_to)) begin
            stage_next.two = 1'b1;
            stage_next.r0.last = 1'b0;
            stage_next.r1 = r_empty;
            stage_next.r1.send_byte = ChCan;
            stage_next.r1.protocol_state = PH_FAILURE;
            stage_next.r1.last = 1'b1;
          end
        end
      end

      CMD_READ: begin
        stage_next.rd = in_range;
      end

      CMD_RESTART: begin
        phase_next = PH_START;
        expected_block_next = '0;
        block_length_next = '0;
        fill_position_next = '0;
        is_repeat_next = 1'b0;
        received_check_next = '0;
        running_check_next = '0;
        fault_count_next = '0;
        elapsed_ms_next = '0;
        stage_next.r0.send_byte = ChC;
        stage_next.r0.protocol_state = PH_START;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      expected_block <= '0;
      block_length <= '0;
      fill_position <= '0;
      is_repeat <= 1'b0;
      received_check <= '0;
      running_check <= '0;
      fault_count <= '0;
      elapsed_ms <= '0;
      allow_long <= AllowLongRst;
      start_retry <= StartRetryRst;
      pkt_timeout <= TimeoutRst;
      err_limit <= ErrLimitRst;
      stage.valid <= 1'b0;
    end else begin
      if (acc) begin
        phase <= phase_next;
        expected_block <= expected_block_next;
        block_length <= block_length_next;
        fill_position <= fill_position_next;
        is_repeat <= is_repeat_next;
        received_check <= received_check_next;
        running_check <= running_check_next;
        fault_count <= fault_count_next;
        elapsed_ms <= elapsed_ms_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          RegAllowLong:  allow_long <= cfg_data[0];
          RegStartRetry: start_retry <= cfg_data;
          RegTimeout:    pkt_timeout <= cfg_data;
          RegErrLimit:   err_limit <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      stage.valid <= stage_next.valid;
    end
    if (acc) begin
      stage.two <= stage_next.two;
      stage.rd <= stage_next.rd;
      stage.r0 <= stage_next.r0;
      stage.r1 <= stage_next.r1;
    end
  end

`ifndef SYNTHESIS
  // fault count only falls on restart
  assert property (@(posedge clk) disable iff (rst)
    !(acc && command == CMD_RESTART) |=> (fault_count >= $past(fault_count)))
    else $error("fault count decreased without restart");

  // done phases are left only by restart
  assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_SUCCESS || phase == PH_FAILURE) && !(acc && command == CMD_RESTART))
    |=> (phase == $past(phase)))
    else $error("left a done phase without restart");

  assert property (@(posedge clk) disable iff (rst)
    (stage.valid && stage.r0.packet_delivered) |->
    (stage.r0.send_byte == ChAck
     && (stage.r0.packet_length == ShortLen || stage.r0.packet_length == LongLen)))
    else $error("delivery without ack or with a bad length");
`endif

endmodule

// ===== src/xmc_out_queue.sv =====
// result queue: takes one or two result words a cycle, hands out one
// depends on xmc_pkg
module xmc_out_queue import xmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  res_t             d0,
  input  res_t             d1,
  input  logic             pop,
  output res_t             head,
  output logic             not_empty,
  output logic [QCntW-1:0] cnt
);

  res_t             entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW-1:0] wr_ptr_next, rd_ptr_next;
  logic [QCntW-1:0] cnt_next;

  assign head = entries[rd_ptr];
  assign not_empty = (cnt != '0);
  assign wr_ptr_next = wr_ptr + QPtrW'(push_n);
  assign rd_ptr_next = rd_ptr + QPtrW'(pop);
  assign cnt_next = cnt + QCntW'(push_n) - QCntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      cnt <= cnt_next;
    end
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= d0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + QPtrW'(1)] <= d1;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) cnt <= QCntW'(QueueDepth))
    else $error("result queue count beyond depth");

  // admission control upstream must leave room for every push
  assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> ((QCntW + 1)'(cnt) + (QCntW + 1)'(push_n)
                          <= (QCntW + 1)'(QueueDepth) + (QCntW + 1)'(pop)))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> (rd_ptr == wr_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== dv/tb.sv =====
// testbench for xmodem_crc_receiver: directed framing and timer checks, then random
// packet traffic under idle and stall patterns, checked against a behavioral predictor
// depends on xmc_pkg, xmc_in_if, xmc_out_if and the receiver rtl
module tb import xmc_pkg::*; ();

  localparam int QuietLimit = 4000;
  localparam int PhaseWords = 60;

  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_HEADER  = 4'd1,
    ST_NUMBER  = 4'd2,
    ST_COMPL   = 4'd3,
    ST_DATA    = 4'd4,
    ST_CRCHI   = 4'd5,
    ST_CRCLO   = 4'd6,
    ST_READY   = 4'd7,
    ST_SUCCESS = 4'd8,
    ST_FAILURE = 4'd9
  } link_state_t;

  typedef enum {FK_GOOD, FK_REPEAT, FK_BAD_CRC, FK_BAD_NUMBER, FK_BAD_COMPL} frame_kind_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        packet_complete;
    logic        packet_delivered;
    logic [31:0] block_number;
    logic [10:0] packet_length;
    logic [7:0]  read_data;
    logic [3:0]  protocol_state;
    logic        last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  xmc_in_if  req();
  xmc_out_if rsp();

  xmodem_crc_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int idle_pct = 0;
  int stall_pct = 0;
  int mid_tick_pct = 0;
  int words_sent = 0;
  int failures = 0;

  reply_t due_results[$];

  // receiver state as predicted from the accepted words
  logic        cfg_long;
  logic [15:0] cfg_retry;
  logic [15:0] cfg_timeout;
  logic [7:0]  cfg_limit;
  link_state_t rx_state;
  logic [31:0] next_block;
  logic [10:0] frame_len;
  logic [10:0] fill_pos;
  logic        dup_frame;
  logic [15:0] crc_rcvd;
  logic [15:0] crc_run;
  logic [7:0]  fault_cnt;
  logic [15:0] ms_count;
  logic [7:0]  payload[BufferBytes];
  int          written_hi;
  int          burst_n;

  // bitwise ccitt crc, msb first
  function automatic logic [15:0] crc_after_byte(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void clear_link();
    rx_state = ST_START;
    next_block = '0;
    frame_len = '0;
    fill_pos = '0;
    dup_frame = 1'b0;
    crc_rcvd = '0;
    crc_run = '0;
    fault_cnt = '0;
    ms_count = '0;
    written_hi = 0;
  endfunction

  function automatic void bump_faults();
    if (fault_cnt != 8'hFF) fault_cnt++;
  endfunction

  function automatic void queue_reply(logic [7:0] ctl, logic complete, logic delivered,
                                      logic [31:0] bn, logic [10:0] len, logic [7:0] rd);
    reply_t w;
    if (burst_n >= 2) return;
    w.send_valid = (ctl != 8'h00);
    w.send_byte = ctl;
    w.packet_complete = complete;
    w.packet_delivered = delivered;
    w.block_number = bn;
    w.packet_length = len;
    w.read_data = rd;
    w.protocol_state = rx_state;
    w.last = 1'b0;
    due_results.push_back(w);
    burst_n++;
  endfunction

  // framing step for one received byte, returns the control byte to send or zero
  function automatic logic [7:0] frame_byte(logic [7:0] b);
    logic [7:0] nxt;
    logic [7:0] cur;
    logic [7:0] ctl;
    nxt = next_block[7:0] + 8'd1;
    cur = next_block[7:0];
    ctl = 8'h00;
    case (rx_state)
      ST_START, ST_HEADER: begin
        if (b == ChSoh) begin
          rx_state = ST_NUMBER;
          frame_len = ShortLen;
        end else if (b == ChStx && cfg_long && LongBlocksOk) begin
          rx_state = ST_NUMBER;
          frame_len = LongLen;
        end else if (b == ChEot) begin
          rx_state = ST_SUCCESS;
          ctl = ChAck;
        end
      end
      ST_NUMBER: begin
        if (b == nxt) begin
          rx_state = ST_COMPL;
          dup_frame = 1'b0;
        end else if (b == cur) begin
          rx_state = ST_COMPL;
          dup_frame = 1'b1;
        end else if (b == ChSoh || b == ChStx) begin
          rx_state = ST_NUMBER;
        end else begin
          rx_state = ST_HEADER;
        end
      end
      ST_COMPL: begin
        if (b == ~(dup_frame ? cur : nxt)) begin
          fill_pos = '0;
          crc_run = '0;
          rx_state = ST_DATA;
        end else if (b == ChSoh || b == ChStx) begin
          rx_state = ST_NUMBER;
        end else begin
          rx_state = ST_HEADER;
        end
      end
      ST_DATA: begin
        payload[fill_pos[9:0]] = b;
        if (int'(fill_pos) + 1 > written_hi) written_hi = int'(fill_pos) + 1;
        crc_run = crc_after_byte(crc_run, b);
        fill_pos++;
        if (fill_pos >= frame_len) rx_state = ST_CRCHI;
      end
      ST_CRCHI: begin
        crc_rcvd = {b, 8'h00};
        rx_state = ST_CRCLO;
      end
      ST_CRCLO: begin
        crc_rcvd[7:0] = b;
        if (crc_rcvd != crc_run) begin
          bump_faults();
          rx_state = ST_HEADER;
          ctl = ChNak;
        end else begin
          rx_state = dup_frame ? ST_HEADER : ST_READY;
        end
      end
      default: ;
    endcase
    return ctl;
  endfunction

  // retry, timeout, error limit and delivery, in that order
  function automatic void ms_tick();
    logic [31:0] bn;
    if (rx_state == ST_SUCCESS || rx_state == ST_FAILURE) return;
    if (ms_count != 16'hFFFF) ms_count++;
    if (rx_state == ST_START && ms_count > cfg_retry) begin
      queue_reply(ChC, 1'b0, 1'b0, '0, '0, '0);
      ms_count = '0;
    end
    if (ms_count > cfg_timeout) begin
      bump_faults();
      rx_state = ST_HEADER;
      queue_reply(ChNak, 1'b0, 1'b0, '0, '0, '0);
      ms_count = '0;
    end
    if (fault_cnt >= cfg_limit) begin
      rx_state = ST_FAILURE;
      queue_reply(ChCan, 1'b0, 1'b0, '0, '0, '0);
      ms_count = '0;
    end
    if (rx_state == ST_READY) begin
      bn = next_block;
      ms_count = '0;
      next_block++;
      rx_state = ST_HEADER;
      queue_reply(ChAck, 1'b0, 1'b1, bn, frame_len, '0);
    end
  endfunction

  function automatic void rx_step(cmd_t c, logic [7:0] b, logic [9:0] idx);
    reply_t     w;
    logic [7:0] ctl;
    burst_n = 0;
    case (c)
      CMD_BYTE: begin
        ctl = frame_byte(b);
        queue_reply(ctl, rx_state == ST_READY, 1'b0, '0, '0, '0);
      end
      CMD_TICK: begin
        ms_tick();
        if (burst_n == 0) queue_reply(8'h00, 1'b0, 1'b0, '0, '0, '0);
      end
      CMD_READ: queue_reply(8'h00, 1'b0, 1'b0, '0, '0, payload[idx]);
      default: begin
        clear_link();
        queue_reply(ChC, 1'b0, 1'b0, '0, '0, '0);
      end
    endcase
    w = due_results.pop_back();
    w.last = 1'b1;
    due_results.push_back(w);
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_word(cmd_t c, logic [7:0] b, logic [9:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= c;
    req.rx_data <= b;
    req.read_index <= idx;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    rx_step(c, b, idx);
    words_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(CMD_BYTE, b, 10'($urandom_range(1023)));
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 8'($urandom_range(255)), 10'($urandom_range(1023)));
  endtask

  task automatic send_restart();
    send_word(CMD_RESTART, 8'($urandom_range(255)), 10'($urandom_range(1023)));
  endtask

  // only entries filled since the last restart are read
  task automatic send_read(int idx);
    if (idx < written_hi) send_word(CMD_READ, 8'($urandom_range(255)), 10'(idx));
  endtask

  task automatic send_packet(frame_kind_t kind, bit long_blk);
    logic [7:0]  num;
    logic [7:0]  body;
    logic [15:0] crc;
    int          len;
    len = long_blk ? 1024 : 128;
    num = (kind == FK_REPEAT) ? next_block[7:0] : next_block[7:0] + 8'd1;
    send_byte(long_blk ? ChStx : ChSoh);
    if (kind == FK_BAD_NUMBER) begin
      send_byte(num ^ (8'd1 << $urandom_range(7)));
      return;
    end
    send_byte(num);
    if (kind == FK_BAD_COMPL) begin
      send_byte(~num ^ (8'd1 << $urandom_range(7)));
      return;
    end
    send_byte(~num);
    crc = 16'h0000;
    for (int i = 0; i < len; i++) begin
      body = 8'($urandom_range(255));
      crc = crc_after_byte(crc, body);
      send_byte(body);
      if ($urandom_range(99) < mid_tick_pct) send_tick();
    end
    if (kind == FK_BAD_CRC) crc ^= 16'd1 << $urandom_range(15);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // config writes need the block idle: all results back and req.valid low
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic lng, logic [15:0] retry, logic [15:0] tmo, logic [7:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= RegAllowLong;
    cfg_data <= {15'd0, lng};
    @(posedge clk);
    cfg_index <= RegStartRetry;
    cfg_data <= retry;
    @(posedge clk);
    cfg_index <= RegTimeout;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= RegErrLimit;
    cfg_data <= {8'd0, lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_long = lng;
    cfg_retry = retry;
    cfg_timeout = tmo;
    cfg_limit = lim;
  endtask

  // ---------------------------------------------------------------- tests

  // header, number and complement handling at the reset settings
  task automatic test_link_control();
    send_tick();
    send_restart();
    send_byte(8'h55);
    send_byte(ChSoh);
    send_byte(ChSoh);
    send_byte(8'h07);
    send_byte(ChStx);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(ChEot);
    send_byte(8'hFF);
    send_tick();
    send_restart();
    wait_idle();
  endtask

  // long blocks off, 'C' retry, then a timeout that also hits the error limit
  task automatic test_timer_events();
    set_config(1'b0, 16'd1, 16'd2, 8'd1);
    send_byte(ChStx);
    send_tick();
    send_tick();
    send_byte(ChSoh);
    send_tick();
    send_tick();
    send_tick();
    send_restart();
    wait_idle();
  endtask

  task automatic test_traffic(logic lng, logic [15:0] retry, logic [15:0] tmo, logic [7:0] lim,
                              int idle, int stall, int tick_mid, bit with_long);
    int first;
    int pick;
    set_config(lng, retry, tmo, lim);
    idle_pct = idle;
    stall_pct = stall;
    mid_tick_pct = tick_mid;
    first = words_sent;
    send_restart();
    if (with_long) begin
      // a long header and the start of its data, read back, then abandoned
      send_byte(ChStx);
      send_byte(next_block[7:0] + 8'd1);
      send_byte(~(next_block[7:0] + 8'd1));
      repeat (16) send_byte(8'($urandom_range(255)));
      send_read(0);
      send_read(15);
      repeat (2) send_read($urandom_range(15));
      send_restart();
    end
    while (words_sent - first < PhaseWords) begin
      pick = $urandom_range(99);
      if ((rx_state == ST_SUCCESS || rx_state == ST_FAILURE) && pick < 80) begin
        send_restart();
      end else if (pick < 45) begin
        send_packet(FK_GOOD, 1'b0);
        if ($urandom_range(9) < 8) send_tick();
      end else if (pick < 55) begin
        send_packet(FK_REPEAT, 1'b0);
      end else if (pick < 63) begin
        send_packet(FK_BAD_CRC, 1'b0);
      end else if (pick < 68) begin
        send_packet(FK_BAD_NUMBER, 1'b0);
      end else if (pick < 73) begin
        send_packet(FK_BAD_COMPL, 1'b0);
      end else if (pick < 81) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else if (pick < 89) begin
        if (written_hi > 0) repeat ($urandom_range(1, 3)) send_read($urandom_range(written_hi - 1));
      end else if (pick < 92) begin
        send_byte(ChEot);
      end else if (pick < 94) begin
        send_restart();
      end else begin
        if ($urandom_range(1)) send_tick();
        else send_byte(8'($urandom_range(255)));
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void compare_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      failures++;
      if (failures <= 10) $display("mismatch in %s: expected %0h, got %0h", fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          failures++;
          if (failures <= 10) $display("result word with nothing outstanding, state %0d",
                                       rsp.protocol_state);
        end else begin
          want = due_results.pop_front();
          compare_field("send_valid", rsp.send_valid, want.send_valid);
          compare_field("send_byte", rsp.send_byte, want.send_byte);
          compare_field("packet_complete", rsp.packet_complete, want.packet_complete);
          compare_field("packet_delivered", rsp.packet_delivered, want.packet_delivered);
          compare_field("block_number", rsp.block_number, want.block_number);
          compare_field("packet_length", rsp.packet_length, want.packet_length);
          compare_field("read_data", rsp.read_data, want.read_data);
          compare_field("protocol_state", rsp.protocol_state, want.protocol_state);
          compare_field("last", rsp.last, want.last);
        end
      end
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ends the run after too many cycles with no word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_BYTE;
    req.rx_data = 8'h00;
    req.read_index = 10'd0;
    cfg_we = 1'b0;
    cfg_index = RegAllowLong;
    cfg_data = 16'h0000;
    cfg_long = AllowLongRst;
    cfg_retry = StartRetryRst;
    cfg_timeout = TimeoutRst;
    cfg_limit = ErrLimitRst;
    clear_link();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_link_control();
    test_timer_events();
    test_traffic(1'b1, 16'd500, 16'd1000, 8'd10, 0, 0, 0, 1'b1);
    test_traffic(1'b0, 16'd1, 16'd1, 8'd1, 76, 0, 2, 1'b0);
    test_traffic(1'b1, 16'd3, 16'd6, 8'd3, 0, 76, 3, 1'b0);
    test_traffic(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 36, 36, 1, 1'b0);

    // catch any stray result words
    repeat (10) @(posedge clk);
    if (failures == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/xmc_pkg.sv
src/xmc_in_if.sv
src/xmc_out_if.sv
src/xmc_payload_ram.sv
src/xmc_ctrl.sv
src/xmc_out_queue.sv
src/xmodem_crc_receiver.sv
dv/tb.sv
